>>> hw/rtl/cop_pkg.sv
// Shared types for the circle overlap push vector pipeline.
package cop_pkg;

  // Per-item flags that ride alongside the divider lanes.
  typedef struct packed {
    logic coll;
    logic zero;
    logic pos_x;
    logic pos_y;
  } cop_flags_t;

endpackage

>>> hw/rtl/cop_sqrt.sv
// Pipelined integer square root, one root bit resolved per register stage.
module cop_sqrt #(
  parameter int IN_W   = 33,
  parameter int ROOT_W = 17,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   in_radicand,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int PAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic [PAD_W-1:0]  rad  [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  logic [SIDE_W-1:0] side [0:ROOT_W];
  logic              vld  [0:ROOT_W];

  assign rad[0]  = PAD_W'(in_radicand);
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0] cat;
    logic [REM_W-1:0] trial;
    logic             ge;

    // The remainder never exceeds twice the partial root, so its top two bits
    // are zero before the shift.
    assign cat   = {rem[i][REM_W-3:0], rad[i][PAD_W-1 -: 2]};
    assign trial = {root[i], 2'b01};
    assign ge    = (cat >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rad[i+1]  <= {rad[i][PAD_W-3:0], 2'b00};
        rem[i+1]  <= ge ? (cat - trial) : cat;
        root[i+1] <= {root[i][ROOT_W-2:0], ge};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

>>> hw/rtl/cop_div.sv
// Two-lane pipelined restoring divider, one quotient bit per register stage.
module cop_div #(
  parameter int Q_W = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*Q_W-1:0]    in_num_a,
  input  logic [2*Q_W-1:0]    in_num_b,
  input  logic [Q_W:0]        in_den,
  input  cop_pkg::cop_flags_t in_flags,
  input  logic [Q_W-1:0]      in_sum,
  output logic                out_valid,
  output logic [Q_W-1:0]      out_quo_a,
  output logic [Q_W-1:0]      out_quo_b,
  output cop_pkg::cop_flags_t out_flags,
  output logic [Q_W-1:0]      out_sum
);

  import cop_pkg::*;

  logic [Q_W:0]   rem_a [0:Q_W];
  logic [Q_W:0]   rem_b [0:Q_W];
  logic [Q_W-1:0] low_a [0:Q_W];
  logic [Q_W-1:0] low_b [0:Q_W];
  logic [Q_W:0]   den   [0:Q_W];
  cop_flags_t     flg   [0:Q_W];
  logic [Q_W-1:0] sum   [0:Q_W];
  logic           vld   [0:Q_W];

  // The quotient fits Q_W bits whenever the upper half is below the divisor,
  // which holds for every overlapping pair with distinct centres.
  assign rem_a[0] = {1'b0, in_num_a[2*Q_W-1:Q_W]};
  assign rem_b[0] = {1'b0, in_num_b[2*Q_W-1:Q_W]};
  assign low_a[0] = in_num_a[Q_W-1:0];
  assign low_b[0] = in_num_b[Q_W-1:0];
  assign den[0]   = in_den;
  assign flg[0]   = in_flags;
  assign sum[0]   = in_sum;
  assign vld[0]   = in_valid;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [Q_W+1:0] cat_a;
    logic [Q_W+1:0] cat_b;
    logic [Q_W+1:0] dd;
    logic           ge_a;
    logic           ge_b;
    logic [Q_W+1:0] sub_a;
    logic [Q_W+1:0] sub_b;

    assign cat_a = {rem_a[i], low_a[i][Q_W-1]};
    assign cat_b = {rem_b[i], low_b[i][Q_W-1]};
    assign dd    = {1'b0, den[i]};
    assign ge_a  = (cat_a >= dd);
    assign ge_b  = (cat_b >= dd);
    assign sub_a = ge_a ? (cat_a - dd) : cat_a;
    assign sub_b = ge_b ? (cat_b - dd) : cat_b;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        rem_a[i+1] <= sub_a[Q_W:0];
        rem_b[i+1] <= sub_b[Q_W:0];
        low_a[i+1] <= {low_a[i][Q_W-2:0], ge_a};
        low_b[i+1] <= {low_b[i][Q_W-2:0], ge_b};
        den[i+1]   <= den[i];
        flg[i+1]   <= flg[i];
        sum[i+1]   <= sum[i];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo_a = low_a[Q_W];
  assign out_quo_b = low_b[Q_W];
  assign out_flags = flg[Q_W];
  assign out_sum   = sum[Q_W];

endmodule

>>> hw/rtl/circle_overlap_push_vector.sv
// Top level of the circle overlap test with push-out vector.
// Takes one circle pair per beat and returns one result beat per pair: the
// overlap flag and the signed integer vector that moves the first circle out
// of the second. A new pair is accepted every cycle unless the output stalls.
// The square root resolves one bit per stage (COORD_WIDTH+1 stages) and the
// divider one quotient bit per stage (COORD_WIDTH stages). The whole
// pipeline advances together and holds when a finished beat is not taken.
module circle_overlap_push_vector #(
  parameter int COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // first_x, first_y, first_radius, second_x, second_y, second_radius
  input  logic [((6*COORD_WIDTH-2+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // colliding, push_x, push_y
  output logic [((2*COORD_WIDTH+3+7)/8)*8-1:0] m_tdata
);

  import cop_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int OUT_TW = ((2*COORD_WIDTH+3+7)/8)*8;
  localparam int SIDE_W = 3*W + 2;

  logic [W-1:0] first_x, first_y, second_x, second_y;
  logic [W-2:0] first_radius, second_radius;

  assign first_x       = s_tdata[W-1:0];
  assign first_y       = s_tdata[2*W-1:W];
  assign first_radius  = s_tdata[3*W-2:2*W];
  assign second_x      = s_tdata[4*W-2:3*W-1];
  assign second_y      = s_tdata[5*W-2:4*W-1];
  assign second_radius = s_tdata[6*W-3:5*W-1];

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage 1: differences and radius sum.
  logic         v1;
  logic [W:0]   dx1, dy1;
  logic [W-1:0] sum1;
  // Stage 2: magnitudes and signs.
  logic         v2;
  logic [W-1:0] ax2, ay2, sum2;
  logic         px2, py2;
  logic [W:0]   ndx, ndy;
  // Stage 3: squares.
  logic           v3;
  logic [2*W-1:0] sqx3, sqy3;
  logic [W-1:0]   ax3, ay3, sum3;
  logic           px3, py3;
  // Stage 4: sum of squares.
  logic         v4;
  logic [2*W:0] ss4;
  logic [W-1:0] ax4, ay4, sum4;
  logic         px4, py4;

  assign ndx = -dx1;
  assign ndy = -dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    if (adv) begin
      dx1  <= {second_x[W-1], second_x} - {first_x[W-1], first_x};
      dy1  <= {second_y[W-1], second_y} - {first_y[W-1], first_y};
      sum1 <= {1'b0, first_radius} + {1'b0, second_radius};

      ax2  <= dx1[W] ? ndx[W-1:0] : dx1[W-1:0];
      ay2  <= dy1[W] ? ndy[W-1:0] : dy1[W-1:0];
      px2  <= !dx1[W] && (dx1 != '0);
      py2  <= !dy1[W] && (dy1 != '0);
      sum2 <= sum1;

      sqx3 <= ax2 * ax2;
      sqy3 <= ay2 * ay2;
      ax3  <= ax2;
      ay3  <= ay2;
      px3  <= px2;
      py3  <= py2;
      sum3 <= sum2;

      ss4  <= {1'b0, sqx3} + {1'b0, sqy3};
      ax4  <= ax3;
      ay4  <= ay3;
      px4  <= px3;
      py4  <= py3;
      sum4 <= sum3;
    end
  end

  logic              rv;
  logic [W:0]        root;
  logic [SIDE_W-1:0] rside;
  logic [W-1:0]      rax, ray, rsum;
  logic              rpx, rpy;

  cop_sqrt #(
    .IN_W   (2*W + 1),
    .ROOT_W (W + 1),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (v4),
    .in_radicand (ss4),
    .in_side     ({ax4, ay4, px4, py4, sum4}),
    .out_valid   (rv),
    .out_root    (root),
    .out_side    (rside)
  );

  assign {rax, ray, rpx, rpy, rsum} = rside;

  // Stage 5: overlap test and penetration depth.
  logic         v5;
  logic [W:0]   dist5;
  logic [W-1:0] pen5, ax5, ay5, sum5;
  cop_flags_t   flg5;
  // Stage 6: numerators of the push components.
  logic           v6;
  logic [2*W-1:0] pa6, pb6;
  logic [W:0]     dist6;
  logic [W-1:0]   sum6;
  cop_flags_t     flg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (adv) begin
      v5 <= rv;
      v6 <= v5;
    end
    if (adv) begin
      dist5      <= root;
      flg5.coll  <= (root < {1'b0, rsum});
      flg5.zero  <= (root == '0);
      flg5.pos_x <= rpx;
      flg5.pos_y <= rpy;
      // Only meaningful when overlapping, where the root is below the sum.
      pen5       <= rsum - root[W-1:0];
      ax5        <= rax;
      ay5        <= ray;
      sum5       <= rsum;

      pa6   <= ax5 * pen5;
      pb6   <= ay5 * pen5;
      dist6 <= dist5;
      flg6  <= flg5;
      sum6  <= sum5;
    end
  end

  logic         dv;
  logic [W-1:0] qa, qb, dsum;
  cop_flags_t   dflg;

  cop_div #(
    .Q_W (W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v6),
    .in_num_a  (pa6),
    .in_num_b  (pb6),
    .in_den    (dist6),
    .in_flags  (flg6),
    .in_sum    (sum6),
    .out_valid (dv),
    .out_quo_a (qa),
    .out_quo_b (qb),
    .out_flags (dflg),
    .out_sum   (dsum)
  );

  logic [W:0] qa_ext, qb_ext, push_x_next, push_y_next;
  logic [W:0] push_x, push_y;
  logic       colliding;

  assign qa_ext = {1'b0, qa};
  assign qb_ext = {1'b0, qb};

  // The push points away from the second centre, so its sign opposes d.
  always_comb begin
    if (!dflg.coll) begin
      push_x_next = '0;
      push_y_next = '0;
    end else if (dflg.zero) begin
      push_x_next = {1'b0, dsum};
      push_y_next = '0;
    end else begin
      push_x_next = dflg.pos_x ? -qa_ext : qa_ext;
      push_y_next = dflg.pos_y ? -qb_ext : qb_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= dv;
    end
    if (adv) begin
      colliding <= dflg.coll;
      push_x    <= push_x_next;
      push_y    <= push_y_next;
    end
  end

  assign m_tdata = OUT_TW'({push_y, push_x, colliding});

`ifndef SYNTHESIS
  a_apart_no_push: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !colliding |-> push_x == '0 && push_y == '0)
    else $error("push vector nonzero for circles that do not overlap");

  a_stall_only_on_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without a waiting output beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_held_beat_stays: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(push_x) && $stable(push_y))
    else $error("waiting result changed before it was taken");
`endif

endmodule

>>> tb/circle_overlap_push_vector_test.sv
// Self-checking testbench for the circle overlap push vector block.
module circle_overlap_push_vector_test;

  localparam int CW = 16;
  localparam int IN_BITS = ((6*CW-2+7)/8)*8;
  localparam int OUT_BITS = ((2*CW+3+7)/8)*8;
  localparam int LATENCY = 2*CW + 8;

  typedef struct packed {
    logic [CW-2:0] sr;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sx;
    logic [CW-2:0] fr;
    logic signed [CW-1:0] fy;
    logic signed [CW-1:0] fx;
  } pair_t;

  typedef struct packed {
    logic signed [CW:0] py;
    logic signed [CW:0] px;
    logic coll;
  } push_t;

  // Directed row: the pair and, where known at a glance, the expected push.
  typedef struct {
    pair_t p;
    bit known;
    push_t r;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [IN_BITS-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [OUT_BITS-1:0] m_tdata;

  push_t pending_push[$];
  int errors = 0;
  int results_seen = 0;
  int collisions_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_recv = 0;
  bit driving_done = 0;

  circle_overlap_push_vector #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("circle_overlap_push_vector regression: fail");
    $finish;
  end

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [CW:0] push_part(longint d, longint pen, longint cdist);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = (mag * pen) / cdist;
    return (CW+1)'((d > 0) ? -q : q);
  endfunction

  function automatic push_t predict_push(pair_t p);
    push_t r;
    longint dx;
    longint dy;
    longint cdist;
    longint total;
    dx = longint'(p.sx) - longint'(p.fx);
    dy = longint'(p.sy) - longint'(p.fy);
    cdist = longint'(floor_sqrt(dx*dx + dy*dy));
    total = longint'(p.fr) + longint'(p.sr);
    r = '0;
    if (cdist < total) begin
      r.coll = 1'b1;
      if (cdist == 0) r.px = (CW+1)'(total);
      else begin
        r.px = push_part(dx, total - cdist, cdist);
        r.py = push_part(dy, total - cdist, cdist);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, results_seen, got, want);
  endtask

  // Offers one pair and holds it until the block takes it.
  task automatic send_pair(pair_t p, bit known, push_t r);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= IN_BITS'(p);
    pending_push.push_back(known ? r : predict_push(p));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_idle();
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    int mode;
    p = pair_t'({$urandom, $urandom, $urandom});
    mode = $urandom_range(9);
    // Mostly near pairs so that overlaps are common; some small radii.
    if (mode < 6) begin
      p.sx = CW'(p.fx + $signed(CW'($urandom_range(0, 4000))) - 2000);
      p.sy = CW'(p.fy + $signed(CW'($urandom_range(0, 4000))) - 2000);
      if (mode < 2) begin
        p.fr = (CW-1)'($urandom_range(0, 2000));
        p.sr = (CW-1)'($urandom_range(0, 2000));
      end
    end else if (mode == 6) begin
      p.sx = p.fx;
      p.sy = p.fy;
    end else if (mode == 7) begin
      p.fr = (CW-1)'($urandom_range(0, 3));
      p.sr = (CW-1)'($urandom_range(0, 3));
      p.sx = CW'(p.fx + $signed(CW'($urandom_range(0, 8))) - 4);
      p.sy = CW'(p.fy + $signed(CW'($urandom_range(0, 8))) - 4);
    end
    return p;
  endfunction

  // Receiver: stalls at random, or for a long stretch when asked.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (hold_recv > 0) begin
        hold_recv <= hold_recv - 1;
        m_tready <= 0;
      end else begin
        m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
      if (m_tvalid && m_tready) begin
        push_t got;
        push_t want;
        got = push_t'(m_tdata[2*CW+2:0]);
        results_seen++;
        if (pending_push.size() == 0) begin
          errors++;
          $display("unexpected result beat %0d", results_seen);
        end else begin
          want = pending_push.pop_front();
          if (got.coll) collisions_seen++;
          if (got.coll !== want.coll) report_mismatch("colliding", got.coll, want.coll);
          if (got.px !== want.px) report_mismatch("push_x", got.px, want.px);
          if (got.py !== want.py) report_mismatch("push_y", got.py, want.py);
        end
      end
    end
  end

  localparam logic signed [CW-1:0] XMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] XMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-2:0] RMAX = '1;

  function automatic row_t mk(logic signed [CW-1:0] fx, logic signed [CW-1:0] fy,
                              logic [CW-2:0] fr, logic signed [CW-1:0] sx,
                              logic signed [CW-1:0] sy, logic [CW-2:0] sr,
                              bit known, logic coll, int px, int py);
    row_t t;
    t.p = '{sr: sr, sy: sy, sx: sx, fr: fr, fy: fy, fx: fx};
    t.known = known;
    t.r = '{py: (CW+1)'(py), px: (CW+1)'(px), coll: coll};
    return t;
  endfunction

  initial begin
    row_t rows[$];
    pair_t p;
    push_t none;
    int phase_idle[4];
    int phase_stall[4];
    int long_wait;
    none = '0;
    phase_idle = '{0, 64, 0, 27};
    phase_stall = '{0, 0, 64, 27};

    rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
    rows.push_back(mk(0, 0, 16, 0, 0, 16, 1, 1, 32, 0));
    rows.push_back(mk(XMIN, XMIN, RMAX, XMIN, XMIN, RMAX, 1, 1, 65534, 0));
    rows.push_back(mk(XMAX, XMAX, 0, XMAX, XMAX, 0, 1, 0, 0, 0));
    rows.push_back(mk(XMIN, XMIN, 0, XMAX, XMAX, 0, 1, 0, 0, 0));
    rows.push_back(mk(XMIN, XMIN, RMAX, XMAX, XMAX, RMAX, 1, 0, 0, 0));
    rows.push_back(mk(XMAX, XMIN, RMAX, XMIN, XMAX, RMAX, 0, 0, 0, 0));
    rows.push_back(mk(XMIN, 0, RMAX, XMAX, 0, RMAX, 0, 0, 0, 0));
    rows.push_back(mk(0, XMIN, RMAX, 0, XMAX, RMAX, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 16, 32, 0, 16, 1, 0, 0, 0));
    rows.push_back(mk(0, 0, 16, 31, 0, 16, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 0, 1, 0, 2, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 1, 0, 1, 0, 1, 0, 0, 0));
    rows.push_back(mk(10, -10, 5, -7, 3, 40, 0, 0, 0, 0));
    rows.push_back(mk(-100, 200, 300, 50, -60, 10, 0, 0, 0, 0));
    rows.push_back(mk(5, 5, 100, 5, 5, 0, 1, 1, 100, 0));
    rows.push_back(mk(XMAX, 0, RMAX, CW'(XMAX - 1), 1, RMAX, 0, 0, 0, 0));
    rows.push_back(mk(0, 0, 50, 3, 4, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 4, 50, 0, 0, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send_pair(rows[i].p, rows[i].known, rows[i].r);
    send_idle();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int n = 0; n < 390; n++) begin
        p = random_pair();
        send_pair(p, 0, none);
        if (n == 100 && ph == 0) begin
          // Long receiver hold while pairs keep coming, filling the pipeline.
          hold_recv <= 3 * LATENCY;
        end
      end
      send_idle();
      // Let everything drain before the next phase.
      while (pending_push.size() != 0) @(posedge clk);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 60; n++) send_pair(random_pair(), 0, none);
    send_idle();

    long_wait = 0;
    while (pending_push.size() != 0 && long_wait < 100000) begin
      @(posedge clk);
      long_wait++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    driving_done = 1;

    $display("checked %0d result beats (%0d overlapping) over %0d directed rows and",
             results_seen, collisions_seen, rows.size());
    $display("four idle/stall mixes plus a long receiver hold");
    if (errors == 0 && pending_push.size() == 0) begin
      $display("circle_overlap_push_vector regression: pass");
    end else begin
      $display("%0d errors, %0d results missing", errors, pending_push.size());
      $display("circle_overlap_push_vector regression: fail");
    end
    $finish;
  end

endmodule
